// ----- hw/rtl/bfsp_pkg.sv -----
// bfsp_pkg: shared types, sizes and codes for the shortest-path block
// no dependencies; imported by bfsp_edge_store, bfsp_relax and the top level
package bfsp_pkg;

  localparam int VERT_DEPTH = 64;
  localparam int MAX_EDGES  = 256;

  localparam int VERT_AW = $clog2(VERT_DEPTH);
  localparam int EDGE_AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int EDGE_CW = $clog2(MAX_EDGES + 1);
  localparam int VCNT_W  = 7;
  localparam int DIST_W  = 32;
  localparam int WGT_W   = 16;

  typedef enum logic [1:0] {
    FUNC_CLEAR  = 2'd0,
    FUNC_APPEND = 2'd1,
    FUNC_SOLVE  = 2'd2,
    FUNC_NONE   = 2'd3
  } func_t;

  typedef struct packed {
    logic [5:0]       from_v;
    logic [5:0]       to_v;
    logic [WGT_W-1:0] weight;
  } edge_t;

  // input word, lowest field in the lowest bits
  typedef struct packed {
    logic [5:0]       pad;
    logic [5:0]       source_vertex;
    logic [WGT_W-1:0] edge_weight;
    logic [5:0]       edge_to;
    logic [5:0]       edge_from;
  } in_word_t;

  typedef struct packed {
    logic              pad;
    logic              reachable;
    logic [DIST_W-1:0] distance;
    logic [5:0]        vertex;
  } out_word_t;

  typedef struct packed {
    logic              upd;
    logic [DIST_W-1:0] cand;
  } relax_t;

endpackage

// ----- hw/rtl/bellman_ford_shortest_paths.sv -----
// bellman_ford_shortest_paths: top level, solve sequencer and distance memory
// depends on bfsp_pkg, bfsp_edge_store, bfsp_relax
// clear and append words are taken in idle and can follow back to back
// a solve is accepted in idle; each pass then reads and checks every edge and relaxes
// those that leave a reached vertex, for up to vertex_count passes; the report then
// reads and sends a word per vertex, waiting on output stalls, a negative cycle one word
// reset (rst_n low, synchronous) empties the edge list, clears reached flags
// and sets vertex_count to 1; no clearing pass is needed.
module bellman_ford_shortest_paths
  import bfsp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [39:0]       in_tdata,  // edge_from, edge_to, edge_weight, source_vertex
  input  logic [1:0]        in_tuser,  // func
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [39:0]       out_tdata, // vertex, distance, reachable
  output logic              out_tuser, // negative_cycle
  output logic              out_tlast,
  input  logic              cfg_wr_en,
  input  logic [VCNT_W-1:0] cfg_wr_data
);

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_EDGE_RD  = 7'b0000010,
    S_EDGE_CHK = 7'b0000100,
    S_RELAX    = 7'b0001000,
    S_EMIT_RD  = 7'b0010000,
    S_EMIT     = 7'b0100000,
    S_OUT      = 7'b1000000
  } state_t;

  state_t                  state_r, state_nxt;
  logic [VCNT_W-1:0]       vcount_r;
  logic [VERT_AW-1:0]      pass_r, pass_nxt;
  logic [EDGE_CW-1:0]      edge_r, edge_nxt;
  logic                    changed_r, changed_nxt;
  logic [VERT_AW-1:0]      v_r, v_nxt;
  logic [VERT_DEPTH-1:0]   reached_r, reached_nxt;

  logic [5:0]        out_vertex_r, out_vertex_nxt;
  logic [DIST_W-1:0] out_dist_r, out_dist_nxt;
  logic              out_reach_r, out_reach_nxt;
  logic              out_neg_r, out_neg_nxt;
  logic              out_last_r, out_last_nxt;

  logic [DIST_W-1:0]  dist_mem [VERT_DEPTH];
  logic [DIST_W-1:0]  da_r, db_r;
  logic               dist_we, dist_re;
  logic [VERT_AW-1:0] dist_waddr, dist_raddr_a, dist_raddr_b;
  logic [DIST_W-1:0]  dist_wdata;

  logic               es_clr, es_app, es_rd_en;
  edge_t              es_rd_data;
  logic [EDGE_CW-1:0] es_total;

  in_word_t          in_w;
  out_word_t         out_w;
  logic              in_acc;
  logic [VCNT_W-1:0] vc_eff;
  logic              last_pass;
  logic              a_in, b_in;
  relax_t            rlx;

  assign in_w   = in_word_t'(in_tdata);
  assign in_acc = in_tvalid && in_tready;

  always_comb begin
    if (vcount_r == '0) begin
      vc_eff = VCNT_W'(1);
    end else if (vcount_r > VCNT_W'(VERT_DEPTH)) begin
      vc_eff = VCNT_W'(VERT_DEPTH);
    end else begin
      vc_eff = vcount_r;
    end
  end

  assign last_pass = (VCNT_W'(pass_r) == vc_eff - VCNT_W'(1));
  assign a_in      = (VCNT_W'(es_rd_data.from_v) < vc_eff);
  assign b_in      = (VCNT_W'(es_rd_data.to_v) < vc_eff);

  bfsp_edge_store u_edges (
    .clk      (clk),
    .rst_n    (rst_n),
    .clr      (es_clr),
    .app_en   (es_app),
    .app_data ({in_w.edge_from, in_w.edge_to, in_w.edge_weight}),
    .rd_en    (es_rd_en),
    .rd_addr  (edge_r[EDGE_AW-1:0]),
    .rd_data  (es_rd_data),
    .total    (es_total)
  );

  bfsp_relax u_relax (
    .dist_a    (da_r),
    .weight    (es_rd_data.weight),
    .dist_b    (db_r),
    .reached_b (reached_r[es_rd_data.to_v[VERT_AW-1:0]]),
    .res       (rlx)
  );

  assign es_clr   = in_acc && (in_tuser == FUNC_CLEAR);
  assign es_app   = in_acc && (in_tuser == FUNC_APPEND);
  assign es_rd_en = (state_r == S_EDGE_RD);

  always_comb begin
    state_nxt      = state_r;
    pass_nxt       = pass_r;
    edge_nxt       = edge_r;
    changed_nxt    = changed_r;
    v_nxt          = v_r;
    reached_nxt    = reached_r;
    out_vertex_nxt = out_vertex_r;
    out_dist_nxt   = out_dist_r;
    out_reach_nxt  = out_reach_r;
    out_neg_nxt    = out_neg_r;
    out_last_nxt   = out_last_r;
    dist_we        = 1'b0;
    dist_waddr     = es_rd_data.to_v[VERT_AW-1:0];
    dist_wdata     = rlx.cand;
    dist_re        = 1'b0;
    dist_raddr_a   = es_rd_data.from_v[VERT_AW-1:0];
    dist_raddr_b   = es_rd_data.to_v[VERT_AW-1:0];

    case (state_r)
      S_IDLE: begin
        if (in_acc && (in_tuser == FUNC_SOLVE)) begin
          reached_nxt = '0;
          if (VCNT_W'(in_w.source_vertex) < vc_eff) begin
            reached_nxt[in_w.source_vertex[VERT_AW-1:0]] = 1'b1;
            dist_we    = 1'b1;
            dist_waddr = in_w.source_vertex[VERT_AW-1:0];
            dist_wdata = '0;
          end
          pass_nxt    = '0;
          edge_nxt    = '0;
          changed_nxt = 1'b0;
          state_nxt   = S_EDGE_RD;
        end
      end
      S_EDGE_RD: begin
        if (edge_r == es_total) begin
          // end of a pass
          if (!changed_r) begin
            v_nxt     = '0;
            state_nxt = S_EMIT_RD;
          end else begin
            pass_nxt    = pass_r + VERT_AW'(1);
            edge_nxt    = '0;
            changed_nxt = 1'b0;
          end
        end else begin
          state_nxt = S_EDGE_CHK;
        end
      end
      S_EDGE_CHK: begin
        if (!a_in || !b_in || !reached_r[es_rd_data.from_v[VERT_AW-1:0]]) begin
          edge_nxt  = edge_r + EDGE_CW'(1);
          state_nxt = S_EDGE_RD;
        end else begin
          dist_re   = 1'b1;
          state_nxt = S_RELAX;
        end
      end
      S_RELAX: begin
        edge_nxt  = edge_r + EDGE_CW'(1);
        state_nxt = S_EDGE_RD;
        if (rlx.upd) begin
          dist_we     = 1'b1;
          reached_nxt[es_rd_data.to_v[VERT_AW-1:0]] = 1'b1;
          changed_nxt = 1'b1;
          if (last_pass) begin
            // still improving in the final pass: negative cycle
            out_vertex_nxt = '0;
            out_dist_nxt   = '0;
            out_reach_nxt  = 1'b0;
            out_neg_nxt    = 1'b1;
            out_last_nxt   = 1'b1;
            state_nxt      = S_OUT;
          end
        end
      end
      S_EMIT_RD: begin
        dist_re      = 1'b1;
        dist_raddr_a = v_r;
        state_nxt    = S_EMIT;
      end
      S_EMIT: begin
        out_vertex_nxt = 6'(v_r);
        out_reach_nxt  = reached_r[v_r];
        out_dist_nxt   = reached_r[v_r] ? da_r : '0;
        out_neg_nxt    = 1'b0;
        out_last_nxt   = (VCNT_W'(v_r) == vc_eff - VCNT_W'(1));
        state_nxt      = S_OUT;
      end
      S_OUT: begin
        if (out_tready) begin
          if (out_last_r) begin
            state_nxt = S_IDLE;
          end else begin
            v_nxt     = v_r + VERT_AW'(1);
            state_nxt = S_EMIT_RD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      vcount_r  <= VCNT_W'(1);
      reached_r <= '0;
      changed_r <= 1'b0;
      pass_r    <= '0;
      edge_r    <= '0;
      v_r       <= '0;
    end else begin
      state_r   <= state_nxt;
      reached_r <= reached_nxt;
      changed_r <= changed_nxt;
      pass_r    <= pass_nxt;
      edge_r    <= edge_nxt;
      v_r       <= v_nxt;
      if (cfg_wr_en) begin
        vcount_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_vertex_r <= out_vertex_nxt;
    out_dist_r   <= out_dist_nxt;
    out_reach_r  <= out_reach_nxt;
    out_neg_r    <= out_neg_nxt;
    out_last_r   <= out_last_nxt;
  end

  // distance memory: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (dist_we) begin
      dist_mem[dist_waddr] <= dist_wdata;
    end
    if (dist_re) begin
      da_r <= dist_mem[dist_raddr_a];
      db_r <= dist_mem[dist_raddr_b];
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);

  always_comb begin
    out_w           = '0;
    out_w.vertex    = out_vertex_r;
    out_w.distance  = out_dist_r;
    out_w.reachable = out_reach_r;
  end

  assign out_tdata = out_w;
  assign out_tuser = out_neg_r;
  assign out_tlast = out_last_r;

`ifndef SYNTH
  a_ready_excl_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !out_tvalid)
    else $error("input ready while a result word is pending");

  a_negcyc_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast && !out_reach_r && (out_dist_r == '0))
    else $error("negative-cycle word malformed");

  a_solve_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == FUNC_SOLVE) |=> !in_tready)
    else $error("ready straight after a solve word");

  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    es_total <= EDGE_CW'(MAX_EDGES))
    else $error("edge count beyond store depth");
`endif

endmodule

// ----- hw/rtl/bfsp_edge_store.sv -----
// bfsp_edge_store: edge memory with fill count, append/clear and one read port
// depends on bfsp_pkg
module bfsp_edge_store
  import bfsp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               clr,
  input  logic               app_en,
  input  edge_t              app_data,
  input  logic               rd_en,
  input  logic [EDGE_AW-1:0] rd_addr,
  output edge_t              rd_data,
  output logic [EDGE_CW-1:0] total
);

  edge_t              mem [MAX_EDGES];
  edge_t              rd_data_r;
  logic [EDGE_CW-1:0] total_r;
  logic [EDGE_CW-1:0] total_nxt;
  logic               wr_ok;

  assign wr_ok = app_en && (total_r < EDGE_CW'(MAX_EDGES));

  always_comb begin
    total_nxt = total_r;
    if (clr) begin
      total_nxt = '0;
    end else if (wr_ok) begin
      total_nxt = total_r + EDGE_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
    end else begin
      total_r <= total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_ok && !clr) begin
      mem[total_r[EDGE_AW-1:0]] <= app_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;
  assign total   = total_r;

endmodule

// ----- hw/rtl/bfsp_relax.sv -----
// bfsp_relax: shared relax unit, saturating add of edge weight and compare
// depends on bfsp_pkg
module bfsp_relax
  import bfsp_pkg::*;
(
  input  logic [DIST_W-1:0] dist_a,
  input  logic [WGT_W-1:0]  weight,
  input  logic [DIST_W-1:0] dist_b,
  input  logic              reached_b,
  output relax_t            res
);

  logic signed [DIST_W:0]   sum;
  logic signed [DIST_W-1:0] cand;

  assign sum = $signed({dist_a[DIST_W-1], dist_a})
             + $signed({{(DIST_W + 1 - WGT_W){weight[WGT_W-1]}}, weight});

  always_comb begin
    if (sum[DIST_W] != sum[DIST_W-1]) begin
      // saturate towards the sign of the true sum
      cand = sum[DIST_W] ? {1'b1, {(DIST_W - 1){1'b0}}} : {1'b0, {(DIST_W - 1){1'b1}}};
    end else begin
      cand = sum[DIST_W-1:0];
    end
  end

  assign res.cand = cand;
  assign res.upd  = !reached_b || ($signed(dist_b) > cand);

endmodule

// ----- test/bellman_ford_shortest_paths_tb.sv -----
// bellman_ford_shortest_paths_tb: self-checking bench for the shortest-path block, with a
// scoreboard class that recomputes distances per solve word and checks every result word
// depends on bfsp_pkg and bellman_ford_shortest_paths
module bellman_ford_shortest_paths_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bfsp_pkg::*;

  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_WORDS  = 200;

  typedef struct {
    logic [5:0] vertex;
    int         distance;
    bit         reachable;
    bit         negative_cycle;
    bit         last;
  } report_t;

  class path_board;
    edge_t             edge_list[MAX_EDGES];
    int unsigned       edge_count;
    int                dist_to[VERT_DEPTH];
    bit                reached[VERT_DEPTH];
    logic [VCNT_W-1:0] vertex_count = VCNT_W'(1);
    report_t           due_reports[$];
    int unsigned       errors, useful_words, solves, cycles_found, reports_checked;

    function void take_word(func_t f, in_word_t w);
      case (f)
        FUNC_CLEAR: begin
          edge_count = 0;
          useful_words++;
        end
        FUNC_APPEND: begin
          // a full store drops the edge
          if (edge_count < MAX_EDGES) begin
            edge_list[edge_count] = '{from_v: w.edge_from, to_v: w.edge_to,
                                      weight: w.edge_weight};
            edge_count++;
            useful_words++;
          end
        end
        FUNC_SOLVE: begin
          relax_from(w.source_vertex);
          solves++;
          useful_words++;
        end
        default: ;
      endcase
    endfunction

    function void push_report(logic [5:0] v, int d, bit r, bit neg, bit lst);
      report_t x;
      x.vertex = v;
      x.distance = d;
      x.reachable = r;
      x.negative_cycle = neg;
      x.last = lst;
      due_reports.push_back(x);
    endfunction

    function void relax_from(logic [5:0] src);
      int unsigned n, p, e;
      logic [5:0] a, b;
      longint sum;
      int cand;
      bit changed;
      n = 32'(vertex_count);
      if (n == 0) n = 1;
      if (n > VERT_DEPTH) n = VERT_DEPTH;
      foreach (reached[i]) reached[i] = 0;
      if (src < n) begin
        dist_to[src] = 0;
        reached[src] = 1;
      end
      for (p = 0; p < n; p++) begin
        changed = 0;
        for (e = 0; e < edge_count; e++) begin
          a = edge_list[e].from_v;
          b = edge_list[e].to_v;
          if (a >= n || b >= n || !reached[a]) continue;
          sum = longint'(dist_to[a]) + longint'($signed(edge_list[e].weight));
          if (sum > 64'sd2147483647) cand = 32'h7fffffff;
          else if (sum < -64'sd2147483648) cand = 32'h80000000;
          else cand = int'(sum);
          if (!reached[b] || dist_to[b] > cand) begin
            dist_to[b] = cand;
            reached[b] = 1;
            changed = 1;
            // still improving in the final pass: reachable negative cycle
            if (p == n - 1) begin
              push_report(6'd0, 0, 1'b0, 1'b1, 1'b1);
              cycles_found++;
              return;
            end
          end
        end
        if (!changed) break;
      end
      for (p = 0; p < n; p++)
        push_report(p[5:0], reached[p] ? dist_to[p] : 0, reached[p], 1'b0, p == n - 1);
    endfunction

    function void compare(string name, logic signed [32:0] want, logic signed [32:0] got);
      if (got !== want) begin
        $display("%t %s mismatch: expected %0d, got %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_report(out_word_t w, logic neg, logic lst);
      report_t x;
      if (due_reports.size() == 0) begin
        $display("%t unexpected result: expected none, got vertex %0d distance %0d",
                 $time, w.vertex, $signed(w.distance));
        errors++;
        return;
      end
      x = due_reports.pop_front();
      reports_checked++;
      compare("vertex", 33'(x.vertex), 33'(w.vertex));
      compare("distance", 33'(x.distance), 33'($signed(w.distance)));
      compare("reachable", 33'(x.reachable), 33'(w.reachable));
      compare("negative_cycle", 33'(x.negative_cycle), 33'(neg));
      compare("last", 33'(x.last), 33'(lst));
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [39:0]       in_tdata = '0;   // edge_from, edge_to, edge_weight, source_vertex
  logic [1:0]        in_tuser = '0;   // func
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [39:0]       out_tdata;       // vertex, distance, reachable
  logic              out_tuser;       // negative_cycle
  logic              out_tlast;
  logic              cfg_wr_en = 1'b0;
  logic [VCNT_W-1:0] cfg_wr_data = '0;

  path_board board;
  bit        steady = 1'b0;

  bellman_ford_shortest_paths uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #100ms;
    $display("Regression FAIL");
    $finish;
  end

  // result side: random back-pressure before each word unless steady is set
  initial begin
    int unsigned stall;
    while (!rst_n) @(posedge clk);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 9);
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      board.check_report(out_tdata, out_tuser, out_tlast);
    end
  end

  function automatic in_word_t make_word(logic [5:0] from_v, logic [5:0] to_v,
                                         logic [15:0] wt, logic [5:0] src);
    in_word_t w;
    w = '0;
    w.edge_from = from_v;
    w.edge_to = to_v;
    w.edge_weight = wt;
    w.source_vertex = src;
    return w;
  endfunction

  function automatic logic [5:0] pick_vertex(int unsigned n);
    if ($urandom_range(0, 9) == 0) return 6'($urandom_range(0, 63));
    return 6'($urandom_range(0, n - 1));
  endfunction

  function automatic logic [15:0] pick_weight(int unsigned style);
    int v;
    case (style)
      6, 7: v = int'($urandom_range(0, 230)) - 30;
      8: v = $urandom;
      9: v = int'($urandom_range(0, 150)) - 100;
      default: v = $urandom_range(0, 200);
    endcase
    return v[15:0];
  endfunction

  task automatic send_word(func_t f, in_word_t w);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= f;
    in_tdata <= w;
    do @(posedge clk); while (!in_tready);
    board.take_word(f, w);
  endtask

  task automatic add_edge(logic [5:0] from_v, logic [5:0] to_v, logic [15:0] wt);
    send_word(FUNC_APPEND, make_word(from_v, to_v, wt, 6'($urandom_range(0, 63))));
  endtask

  task automatic solve_from(logic [5:0] src);
    send_word(FUNC_SOLVE, make_word(6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                                    16'($urandom), src));
  endtask

  task automatic clear_edges();
    send_word(FUNC_CLEAR, make_word(6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                                    16'($urandom), 6'($urandom_range(0, 63))));
  endtask

  // hold the input off until every outstanding result has arrived
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (board.due_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_count(logic [VCNT_W-1:0] v);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    board.vertex_count = v;
  endtask

  task automatic random_graph();
    int unsigned pick, n, cnt, k, style;
    logic [VCNT_W-1:0] setting;
    pick = $urandom_range(0, 19);
    case (pick)
      0: setting = 7'd0;
      1: setting = 7'd1;
      2: setting = 7'd127;
      3: setting = 7'($urandom_range(64, 126));
      default: setting = 7'($urandom_range(2, 12));
    endcase
    steady = ($urandom_range(0, 6) == 0);
    write_count(setting);
    n = (setting == 0) ? 1 : ((setting > VERT_DEPTH) ? VERT_DEPTH : 32'(setting));
    // large graphs always start empty to keep solve times bounded
    if (n >= VERT_DEPTH || $urandom_range(0, 6) != 0) clear_edges();
    if (n >= VERT_DEPTH) cnt = $urandom_range(4, 30);
    else cnt = $urandom_range(0, (3 * n + 4 > 40) ? 40 : 3 * n + 4);
    style = $urandom_range(0, 9);
    for (k = 0; k < cnt; k++) begin
      if ($urandom_range(0, 19) == 0)
        send_word(FUNC_NONE, make_word(6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                                       16'($urandom), 6'($urandom_range(0, 63))));
      add_edge(pick_vertex(n), pick_vertex(n), pick_weight(style));
    end
    if ($urandom_range(0, 9) == 0) drain();
    k = $urandom_range(1, 3);
    repeat (k) solve_from(pick_vertex(n));
  endtask

  initial begin
    int unsigned k, first;
    board = new;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // one-vertex graph straight out of reset, unused code, source off the graph
    solve_from(6'd0);
    send_word(FUNC_NONE, make_word(6'd63, 6'd63, 16'hffff, 6'd63));
    solve_from(6'd63);

    // count 0 behaves as one vertex; a negative self-loop is a cycle at once
    write_count(7'd0);
    add_edge(6'd0, 6'd0, 16'hffff);
    solve_from(6'd0);
    clear_edges();

    // small chain with extreme weights and edges leaving the graph
    write_count(7'd4);
    add_edge(6'd0, 6'd1, 16'd5);
    add_edge(6'd1, 6'd2, -16'sd3);
    add_edge(6'd2, 6'd3, 16'h7fff);
    add_edge(6'd3, 6'd63, 16'd7);
    add_edge(6'd63, 6'd0, 16'h8000);
    add_edge(6'd0, 6'd3, 16'h8000);
    solve_from(6'd0);
    solve_from(6'd3);
    drain();
    add_edge(6'd2, 6'd1, -16'sd10);
    solve_from(6'd0);
    solve_from(6'd3);
    clear_edges();
    solve_from(6'd1);

    // overfill the edge store; appends past the end are dropped
    write_count(7'd8);
    clear_edges();
    for (k = 0; k < MAX_EDGES + 4; k++)
      add_edge(6'($urandom_range(0, 15)), 6'($urandom_range(0, 15)),
               pick_weight($urandom_range(0, 7)));
    solve_from(6'd0);
    solve_from(6'($urandom_range(0, 7)));
    clear_edges();

    first = board.useful_words;
    while (board.useful_words - first < RANDOM_WORDS) random_graph();

    steady = 1'b0;
    drain();
    repeat (60) @(posedge clk);
    $display("%0d solves over %0d accepted words, %0d result words checked,",
             board.solves, board.useful_words, board.reports_checked);
    $display("%0d negative cycles reported, %0d mismatches",
             board.cycles_found, board.errors);
    if (board.errors == 0 && board.due_reports.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/bfsp_pkg.sv
hw/rtl/bfsp_edge_store.sv
hw/rtl/bfsp_relax.sv
hw/rtl/bellman_ford_shortest_paths.sv
test/bellman_ford_shortest_paths_tb.sv
